@@ hw/rtl/dcdf_pkg.sv @@
// shared constants, types and coefficient table for the dual-channel decimating fir
`default_nettype none

package dcdf_pkg;

  localparam int TAP_COUNT  = 17;
  localparam int DECIMATION = 10;
  localparam int COEF_COUNT = 17;
  localparam int COEF_SHIFT = 16;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  // coefficients sum below 2^16, so the full sum stays below 2^32
  localparam int ACC_W    = SAMPLE_W + COEF_SHIFT;
  localparam int TAP_IDX_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int PHASE_W   = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] accel;
    logic [SAMPLE_W-1:0] gyro;
  } sample_pair_t;

  // q0.16 low-pass taps, zero past the end of the table
  function automatic logic [COEF_W-1:0] coef_at(input logic [TAP_IDX_W-1:0] k);
    logic [COEF_W-1:0] c;
    unique case (int'(k))
      0:       c = COEF_W'(567);
      1:       c = COEF_W'(829);
      2:       c = COEF_W'(1570);
      3:       c = COEF_W'(2693);
      4:       c = COEF_W'(4035);
      5:       c = COEF_W'(5391);
      6:       c = COEF_W'(6550);
      7:       c = COEF_W'(7328);
      8:       c = COEF_W'(7602);
      9:       c = COEF_W'(7328);
      10:      c = COEF_W'(6550);
      11:      c = COEF_W'(5391);
      12:      c = COEF_W'(4035);
      13:      c = COEF_W'(2693);
      14:      c = COEF_W'(1570);
      15:      c = COEF_W'(829);
      16:      c = COEF_W'(567);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dcdf_cell.sv @@
// one history slot holding a gyro and an accelerometer sample
`default_nettype none

module dcdf_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire dcdf_pkg::sample_pair_t prev_i,
  output      dcdf_pkg::sample_pair_t data_o
);
  import dcdf_pkg::*;

  sample_pair_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (en_i) begin
      data_q <= prev_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ hw/rtl/dcdf_mac.sv @@
// registered multiply followed by an accumulator, one channel
`default_nettype none

module dcdf_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clear_i,
  input  wire logic                          en_i,
  input  wire logic [dcdf_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic [dcdf_pkg::COEF_W-1:0]   coef_i,
  output      logic [dcdf_pkg::ACC_W-1:0]    acc_o
);
  import dcdf_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic              prod_vld_q;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  acc_d;

  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(sample_i) * PROD_W'(coef_i);
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

@@ hw/rtl/dual_channel_decimating_fir_top.sv @@
// top level: sample history chain, two macs and the decimation control
//
// channel   dir  tdata fields (low bit up)                 beat
// s_axis    in   gyro_sample[15:0], accel_sample[31:16]    one sample pair
// m_axis    out  gyro_filtered[15:0], accel_filtered[31:16] one filtered pair
//
// a sample beat is taken while idle and shifted into the cell chain.
// on every DECIMATION-th beat the chain rotates once round, one shared
// coefficient feeding a multiplier per channel, then a drain state and a
// load state for the output register, all with tready low.
// a result is held while the next beats come in; the rotation waits to
// load only if the last result is unread.
// reset clears the history to zero and the phase count to zero.
`default_nettype none

module dual_channel_decimating_fir_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // gyro_sample, accel_sample
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o   // gyro_filtered, accel_filtered
);
  import dcdf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_HOLD
  } state_e;

  localparam logic [TAP_IDX_W-1:0] TapLast   = TAP_IDX_W'(TAP_COUNT - 1);
  localparam logic [PHASE_W-1:0]   PhaseLast = PHASE_W'(DECIMATION - 1);

  state_e               state_q;
  logic [TAP_IDX_W-1:0] step_q;
  logic [PHASE_W-1:0]   phase_q;
  logic                 out_vld_q;
  logic [SAMPLE_W-1:0]  out_gyro_q;
  logic [SAMPLE_W-1:0]  out_accel_q;

  logic                 in_acc;
  logic                 last_beat;
  logic                 rotating;
  logic                 chain_en;
  logic                 out_free;
  sample_pair_t         new_pair;
  sample_pair_t         cell_in [TAP_COUNT];
  sample_pair_t         cell_out[TAP_COUNT];
  logic [COEF_W-1:0]    coef;
  logic [ACC_W-1:0]     gyro_acc;
  logic [ACC_W-1:0]     accel_acc;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign last_beat       = (phase_q == PhaseLast);
  assign rotating        = (state_q == ST_RUN);
  assign chain_en        = in_acc || rotating;
  assign out_free        = !out_vld_q || m_axis_tready_i;

  assign new_pair.gyro  = s_axis_tdata_i[15:0];
  assign new_pair.accel = s_axis_tdata_i[31:16];

  // the head takes a new sample on a beat, or the tail sample while rotating
  assign cell_in[0] = rotating ? cell_out[TAP_COUNT-1] : new_pair;

  for (genvar k = 1; k < TAP_COUNT; k++) begin : g_link
    assign cell_in[k] = cell_out[k-1];
  end

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    dcdf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (chain_en),
      .prev_i (cell_in[k]),
      .data_o (cell_out[k])
    );
  end

  // the tail holds the oldest slot first, then steps towards the newest
  assign coef = coef_at(TapLast - step_q);

  dcdf_mac u_mac_gyro (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (in_acc && last_beat),
    .en_i     (rotating),
    .sample_i (cell_out[TAP_COUNT-1].gyro),
    .coef_i   (coef),
    .acc_o    (gyro_acc)
  );

  dcdf_mac u_mac_accel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (in_acc && last_beat),
    .en_i     (rotating),
    .sample_i (cell_out[TAP_COUNT-1].accel),
    .coef_i   (coef),
    .acc_o    (accel_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      phase_q     <= '0;
      out_vld_q   <= 1'b0;
      out_gyro_q  <= '0;
      out_accel_q <= '0;
    end else begin
      // in the load state the output register is handled below
      if (out_vld_q && m_axis_tready_i && (state_q != ST_HOLD)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (last_beat) begin
              phase_q <= '0;
              step_q  <= '0;
              state_q <= ST_RUN;
            end else begin
              phase_q <= phase_q + PHASE_W'(1);
            end
          end
        end
        ST_RUN: begin
          if (step_q == TapLast) begin
            state_q <= ST_DRAIN;
          end else begin
            step_q <= step_q + TAP_IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_gyro_q  <= gyro_acc[ACC_W-1:COEF_SHIFT];
            out_accel_q <= accel_acc[ACC_W-1:COEF_SHIFT];
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_accel_q, out_gyro_q};

endmodule

`default_nettype wire
